// ----- src/aminv_pkg.sv -----
package aminv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EW        = 32;
    localparam int PW        = 2 * EW;
    localparam int CFW       = PW + 1;
    localparam int DTW       = CFW + EW + 1;
    localparam int CMW       = PW;
    localparam int SMW       = DTW;
    localparam int NUM_W     = (CMW + 2 * FRAC_BITS > SMW + FRAC_BITS) ?
                               (CMW + 2 * FRAC_BITS) : (SMW + FRAC_BITS);
    localparam int DEN_W     = DTW;
    localparam int REM_W     = (NUM_W > DEN_W + EW) ? NUM_W : (DEN_W + EW);
    localparam int DIV_STEPS = EW;
    localparam int LANES     = 4;
    localparam int IN_W      = 12 * EW;
    localparam int OUT_W     = 2 + 4 * EW;
    localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8;

    typedef logic signed [EW-1:0] elem_t;
    typedef elem_t [0:2][0:3] mat_t;
    typedef logic [1:0] row_t;

    localparam row_t ROW_LAST = 2'd2;

    localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

    typedef struct packed {
        elem_t x;
        elem_t y;
        elem_t z;
        elem_t w;
    } cofop_t;

    // Cofactor (i,j) of the adjugate is x*y - z*w.
    function automatic cofop_t cof_ops(input mat_t m, input row_t i, input row_t j);
        cofop_t r;
        r = '0;
        case ({i, j})
            4'b0000: r = '{m[1][1], m[2][2], m[1][2], m[2][1]};
            4'b0001: r = '{m[0][2], m[2][1], m[0][1], m[2][2]};
            4'b0010: r = '{m[0][1], m[1][2], m[0][2], m[1][1]};
            4'b0100: r = '{m[1][2], m[2][0], m[1][0], m[2][2]};
            4'b0101: r = '{m[0][0], m[2][2], m[0][2], m[2][0]};
            4'b0110: r = '{m[0][2], m[1][0], m[0][0], m[1][2]};
            4'b1000: r = '{m[1][0], m[2][1], m[1][1], m[2][0]};
            4'b1001: r = '{m[0][1], m[2][0], m[0][0], m[2][1]};
            4'b1010: r = '{m[0][0], m[1][1], m[0][1], m[1][0]};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/affine_matrix_inverse_3x4_core.sv -----
// A new matrix is taken once the row counter issues the last row of the one before;
// earlier matrices may still be in flight. Its three rows leave on consecutive
// cycles unless stalled, one row per cycle through a 32-stage restoring divider.
// All stages advance together and hold while the output register is stalled.
// Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is empty.
module affine_matrix_inverse_3x4_core
    import aminv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23, 32 bits each.
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // row_index (2), col0, col1, col2, col3 (32 each), zero pad.
    output logic [OUT_DW-1:0] m_axis_tdata,
    // singular.
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);

    logic en;
    logic accept;

    mat_t mat_reg;
    row_t h_row_reg;
    logic h_valid_reg;

    logic                  s1_v_reg;
    row_t                  s1_row_reg;
    logic signed [PW-1:0]  s1_dp_reg [0:2][0:1];
    logic signed [PW-1:0]  s1_rp_reg [0:2][0:1];
    elem_t                 s1_a_reg  [0:2];
    elem_t                 s1_t_reg  [0:2];

    logic                  s2_v_reg;
    row_t                  s2_row_reg;
    logic signed [CFW-1:0] s2_dc_reg [0:2];
    logic signed [CFW-1:0] s2_rc_reg [0:2];
    elem_t                 s2_a_reg  [0:2];
    elem_t                 s2_t_reg  [0:2];

    logic                  s3_v_reg;
    row_t                  s3_row_reg;
    logic signed [CFW-1:0] s3_dlo_reg [0:2];
    logic signed [CFW-1:0] s3_dhi_reg [0:2];
    logic signed [CFW-1:0] s3_rlo_reg [0:2];
    logic signed [CFW-1:0] s3_rhi_reg [0:2];
    logic signed [CFW-1:0] s3_rc_reg  [0:2];

    logic                  s4_v_reg;
    row_t                  s4_row_reg;
    logic signed [DTW-1:0] s4_dt_reg [0:2];
    logic signed [DTW-1:0] s4_rt_reg [0:2];
    logic signed [CFW-1:0] s4_rc_reg [0:2];

    logic                  s5_v_reg;
    row_t                  s5_row_reg;
    logic signed [DTW-1:0] s5_det_reg;
    logic signed [DTW-1:0] s5_s_reg;
    logic signed [CFW-1:0] s5_rc_reg [0:2];

    logic                  s6_v_reg;
    row_t                  s6_row_reg;
    logic                  s6_sing_reg;
    logic [NUM_W-1:0]      s6_num_reg [0:LANES-1];
    logic                  s6_neg_reg [0:LANES-1];
    logic [DEN_W-1:0]      s6_d_reg;

    logic                  dv_v_reg    [0:DIV_STEPS];
    row_t                  dv_row_reg  [0:DIV_STEPS];
    logic                  dv_sing_reg [0:DIV_STEPS];
    logic [DEN_W-1:0]      dv_d_reg    [0:DIV_STEPS];
    logic [REM_W-1:0]      dv_rem_reg  [0:DIV_STEPS][0:LANES-1];
    logic [EW-1:0]         dv_q_reg    [0:DIV_STEPS][0:LANES-1];
    logic                  dv_neg_reg  [0:DIV_STEPS][0:LANES-1];
    logic                  dv_sat_reg  [0:DIV_STEPS][0:LANES-1];

    logic                  ov_reg;
    row_t                  o_row_reg;
    logic [EW-1:0]         o_col_reg [0:LANES-1];
    logic                  o_sing_reg;

    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en && (!h_valid_reg || h_row_reg == ROW_LAST);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
            h_row_reg   <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                h_valid_reg <= 1'b1;
                h_row_reg   <= '0;
            end
            else if (h_valid_reg)
            begin
                if (h_row_reg == ROW_LAST)
                begin
                    h_valid_reg <= 1'b0;
                end
                else
                begin
                    h_row_reg <= h_row_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    mat_reg[r][c] <= s_axis_tdata[(r*4+c)*EW +: EW];
                end
            end
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= h_valid_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cofop_t dop;
        cofop_t rop;
        logic signed [CFW-1:0] rabs;
        logic signed [DTW-1:0] dabs;
        logic signed [DTW-1:0] sabs;
        if (en)
        begin
            // Stage 1: cofactor products.
            s1_row_reg <= h_row_reg;
            for (int k = 0; k < 3; k++)
            begin
                dop = cof_ops(mat_reg, row_t'(k), 2'd0);
                rop = cof_ops(mat_reg, h_row_reg, row_t'(k));
                s1_dp_reg[k][0] <= $signed(dop.x) * $signed(dop.y);
                s1_dp_reg[k][1] <= $signed(dop.z) * $signed(dop.w);
                s1_rp_reg[k][0] <= $signed(rop.x) * $signed(rop.y);
                s1_rp_reg[k][1] <= $signed(rop.z) * $signed(rop.w);
                s1_a_reg[k]     <= mat_reg[0][k];
                s1_t_reg[k]     <= mat_reg[k][3];
            end

            // Stage 2: cofactors.
            s2_row_reg <= s1_row_reg;
            for (int k = 0; k < 3; k++)
            begin
                s2_dc_reg[k] <= CFW'(s1_dp_reg[k][0]) - CFW'(s1_dp_reg[k][1]);
                s2_rc_reg[k] <= CFW'(s1_rp_reg[k][0]) - CFW'(s1_rp_reg[k][1]);
                s2_a_reg[k]  <= s1_a_reg[k];
                s2_t_reg[k]  <= s1_t_reg[k];
            end

            // Stage 3: split 65x32 products into two 33x32 partial products.
            s3_row_reg <= s2_row_reg;
            for (int k = 0; k < 3; k++)
            begin
                s3_dlo_reg[k] <= $signed({1'b0, s2_dc_reg[k][EW-1:0]}) * s2_a_reg[k];
                s3_dhi_reg[k] <= $signed(s2_dc_reg[k][CFW-1:EW]) * s2_a_reg[k];
                s3_rlo_reg[k] <= $signed({1'b0, s2_rc_reg[k][EW-1:0]}) * s2_t_reg[k];
                s3_rhi_reg[k] <= $signed(s2_rc_reg[k][CFW-1:EW]) * s2_t_reg[k];
                s3_rc_reg[k]  <= s2_rc_reg[k];
            end

            // Stage 4: recombine partial products.
            s4_row_reg <= s3_row_reg;
            for (int k = 0; k < 3; k++)
            begin
                s4_dt_reg[k] <= (DTW'(s3_dhi_reg[k]) <<< EW) + DTW'(s3_dlo_reg[k]);
                s4_rt_reg[k] <= (DTW'(s3_rhi_reg[k]) <<< EW) + DTW'(s3_rlo_reg[k]);
                s4_rc_reg[k] <= s3_rc_reg[k];
            end

            // Stage 5: determinant and translation sum.
            s5_row_reg <= s4_row_reg;
            s5_det_reg <= s4_dt_reg[0] + s4_dt_reg[1] + s4_dt_reg[2];
            s5_s_reg   <= s4_rt_reg[0] + s4_rt_reg[1] + s4_rt_reg[2];
            for (int k = 0; k < 3; k++)
            begin
                s5_rc_reg[k] <= s4_rc_reg[k];
            end

            // Stage 6: magnitudes, scaled numerators and result signs.
            s6_row_reg  <= s5_row_reg;
            s6_sing_reg <= (s5_det_reg == '0);
            dabs = s5_det_reg[DTW-1] ? -s5_det_reg : s5_det_reg;
            s6_d_reg <= DEN_W'(unsigned'(dabs));
            for (int k = 0; k < 3; k++)
            begin
                rabs = s5_rc_reg[k][CFW-1] ? -s5_rc_reg[k] : s5_rc_reg[k];
                s6_num_reg[k] <= NUM_W'(unsigned'(rabs)) << (2 * FRAC_BITS);
                s6_neg_reg[k] <= s5_rc_reg[k][CFW-1] ^ s5_det_reg[DTW-1];
            end
            sabs = s5_s_reg[DTW-1] ? -s5_s_reg : s5_s_reg;
            s6_num_reg[3] <= NUM_W'(unsigned'(sabs)) << FRAC_BITS;
            s6_neg_reg[3] <= (!s5_s_reg[DTW-1] && s5_s_reg != '0) ^ s5_det_reg[DTW-1];
        end
    end

    // Divider entry: saturation check, quotient not below 2^32.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_row_reg[0]  <= s6_row_reg;
            dv_sing_reg[0] <= s6_sing_reg;
            dv_d_reg[0]    <= s6_d_reg;
            for (int l = 0; l < LANES; l++)
            begin
                dv_rem_reg[0][l] <= REM_W'(s6_num_reg[l]);
                dv_q_reg[0][l]   <= '0;
                dv_neg_reg[0][l] <= s6_neg_reg[l];
                dv_sat_reg[0][l] <= REM_W'(s6_num_reg[l]) >= (REM_W'(s6_d_reg) << EW);
            end
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        localparam int BIT = DIV_STEPS - k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            logic [REM_W:0] trial;
            if (en)
            begin
                dv_row_reg[k]  <= dv_row_reg[k-1];
                dv_sing_reg[k] <= dv_sing_reg[k-1];
                dv_d_reg[k]    <= dv_d_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    trial = {1'b0, dv_rem_reg[k-1][l]} -
                            {1'b0, (REM_W'(dv_d_reg[k-1]) << BIT)};
                    dv_neg_reg[k][l] <= dv_neg_reg[k-1][l];
                    dv_sat_reg[k][l] <= dv_sat_reg[k-1][l];
                    if (!trial[REM_W])
                    begin
                        dv_rem_reg[k][l] <= trial[REM_W-1:0];
                        dv_q_reg[k][l]   <= dv_q_reg[k-1][l] | (EW'(1) << BIT);
                    end
                    else
                    begin
                        dv_rem_reg[k][l] <= dv_rem_reg[k-1][l];
                        dv_q_reg[k][l]   <= dv_q_reg[k-1][l];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [EW-1:0] q;
        if (en)
        begin
            o_row_reg  <= dv_row_reg[DIV_STEPS];
            o_sing_reg <= dv_sing_reg[DIV_STEPS];
            for (int l = 0; l < LANES; l++)
            begin
                q = dv_q_reg[DIV_STEPS][l];
                if (dv_sing_reg[DIV_STEPS])
                begin
                    o_col_reg[l] <= '0;
                end
                else if (!dv_neg_reg[DIV_STEPS][l])
                begin
                    o_col_reg[l] <= (dv_sat_reg[DIV_STEPS][l] || q > SAT_POS) ? SAT_POS : q;
                end
                else
                begin
                    o_col_reg[l] <= (dv_sat_reg[DIV_STEPS][l] || q > SAT_NEG) ? SAT_NEG : -q;
                end
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {{(OUT_DW-OUT_W){1'b0}}, o_col_reg[3], o_col_reg[2],
                            o_col_reg[1], o_col_reg[0], o_row_reg};
    assign m_axis_tuser  = o_sing_reg;
    assign m_axis_tlast  = (o_row_reg == ROW_LAST);

endmodule

// ----- src/aminv_chk.sv -----
module aminv_chk
    import aminv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == ROW_LAST)))
        else $error("tlast does not match the last row");

    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
        else $error("row index out of range");

    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[OUT_W-1:2] == '0))
        else $error("singular row carries nonzero data");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before its rows were issued");

endmodule

bind affine_matrix_inverse_3x4_core aminv_chk u_aminv_chk (.*);
